/* hw/rtl/cpr_pkg.sv */
package cpr_pkg;

	localparam int CAP_W     = 5;
	localparam int CAP_RESET = 16;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [ADDR_W-1:0] ADDR_POOL_CAPACITY = 3'h0;

	typedef struct packed {
		logic load;
		logic match;
		logic step;
		logic sweep;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
		logic out_free;
	} dp_sts_t;

endpackage

/* hw/rtl/clock_page_replacement.sv */
// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall  page_id
// result    out        out_valid/out_stall hit, evicted, victim_page, frame_index
// config    in         APB write/read     pool_capacity at byte address 0
//
// On a hit or a fill of an empty hand frame below capacity an item passes the load, match
// and decide states; other misses then sweep one frame a cycle, the last step held by a stalled result.
// The next item is taken once the current one has reached the result register.
// Reset clears valid and reference bits, the hand and the resident count.
// A stalled result holds the last step of the next item, nothing else.
module clock_page_replacement
	import cpr_pkg::*;
#(
	parameter int FRAMES    = 16,
	parameter int PAGE_BITS = 16,
	localparam int IDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [PAGE_BITS-1:0] page_id,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 hit,
	output logic                 evicted,
	output logic [PAGE_BITS-1:0] victim_page,
	output logic [IDX_W-1:0]     frame_index,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready
);

	logic [CAP_W-1:0] cap_q;
	dp_cmd_t          cmd;
	dp_sts_t          sts;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_POOL_CAPACITY) ? DATA_W'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(CAP_RESET);
		end else if (psel && penable && pwrite && pready
		             && (paddr == ADDR_POOL_CAPACITY)) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	cpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	cpr_dp #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS),
		.IDX_W     (IDX_W)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cap         (cap_q),
		.page_id     (page_id),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.hit         (hit),
		.evicted     (evicted),
		.victim_page (victim_page),
		.frame_index (frame_index)
	);

endmodule

/* hw/rtl/cpr_ctrl.sv */
module cpr_ctrl
	import cpr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_MATCH  = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;
	localparam logic [1:0] ST_SWEEP  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       step_en;

	assign step_en  = sts.out_free || !sts.done;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d   = state_q;
		cmd.load  = 1'b0;
		cmd.match = 1'b0;
		cmd.step  = 1'b0;
		cmd.sweep = (state_q == ST_SWEEP);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MATCH;
				end
			end
			ST_MATCH: begin
				cmd.match = 1'b1;
				state_d   = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (step_en) begin
					cmd.step = 1'b1;
					state_d  = sts.done ? ST_IDLE : ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (step_en) begin
					cmd.step = 1'b1;
					if (sts.done) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hw/rtl/cpr_dp.sv */
module cpr_dp
	import cpr_pkg::*;
#(
	parameter int FRAMES    = 16,
	parameter int PAGE_BITS = 16,
	parameter int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_sts_t              sts,
	input  logic [CAP_W-1:0]     cap,
	input  logic [PAGE_BITS-1:0] page_id,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic                 hit,
	output logic                 evicted,
	output logic [PAGE_BITS-1:0] victim_page,
	output logic [IDX_W-1:0]     frame_index
);

	localparam int CNT_W = $clog2(FRAMES + 1);
	localparam int EW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [PAGE_BITS-1:0] frame_page_q [FRAMES];
	logic [FRAMES-1:0]    valid_q;
	logic [FRAMES-1:0]    ref_q;
	logic [IDX_W-1:0]     hand_q;
	logic [CNT_W-1:0]     count_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [FRAMES-1:0]    match_s1;

	logic                 out_valid_q;
	logic                 hit_q;
	logic                 evicted_q;
	logic [PAGE_BITS-1:0] victim_q;
	logic [IDX_W-1:0]     frame_q;

	logic [EW-1:0]        cap_w;
	logic [CNT_W-1:0]     eff_cap;
	logic [CNT_W-1:0]     hand_ext;
	logic [CNT_W-1:0]     hand_inc;
	logic [IDX_W-1:0]     hand_nx;
	logic [FRAMES-1:0]    match_c;
	logic [IDX_W-1:0]     hit_idx;
	logic                 hit_c;
	logic                 fill_ok;
	logic                 hand_valid;
	logic                 hand_ref;
	logic                 do_hit_set;
	logic                 do_fill;
	logic                 do_clear;
	logic                 do_evict;
	logic                 fire;

	assign cap_w    = EW'(cap);
	assign eff_cap  = (cap_w == '0) ? CNT_W'(1) :
	                  ((cap_w > EW'(FRAMES)) ? CNT_W'(FRAMES) : CNT_W'(cap_w));
	assign hand_ext = CNT_W'(hand_q);
	assign hand_inc = hand_ext + CNT_W'(1);
	assign hand_nx  = (hand_inc >= eff_cap) ? '0 : IDX_W'(hand_inc);

	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			match_c[i] = valid_q[i] && (frame_page_q[i] == page_q);
		end
	end

	// at most one frame holds a given page, so OR the indexes together
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < FRAMES; i++) begin
			if (match_s1[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
		end
	end

	assign hit_c      = |match_s1;
	assign hand_valid = valid_q[hand_q];
	assign hand_ref   = ref_q[hand_q];
	assign fill_ok    = (count_q < eff_cap) && !hand_valid;

	assign do_hit_set = cmd.step && !cmd.sweep && hit_c;
	assign do_fill    = cmd.step && (cmd.sweep ? !hand_valid : (!hit_c && fill_ok));
	assign do_clear   = cmd.step && cmd.sweep && hand_valid && hand_ref;
	assign do_evict   = cmd.step && cmd.sweep && hand_valid && !hand_ref;
	assign fire       = do_hit_set || do_fill || do_evict;

	assign sts.done     = cmd.sweep ? (!hand_valid || !hand_ref) : (hit_c || fill_ok);
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			ref_q       <= '0;
			hand_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load && (hand_ext >= eff_cap)) begin
				hand_q <= '0;
			end
			if (do_hit_set) begin
				ref_q[hit_idx] <= 1'b1;
			end
			if (do_fill || do_evict) begin
				valid_q[hand_q] <= 1'b1;
				ref_q[hand_q]   <= 1'b1;
			end
			if (do_clear) begin
				ref_q[hand_q] <= 1'b0;
			end
			if (do_fill || do_evict || do_clear) begin
				hand_q <= hand_nx;
			end
			if (do_fill) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_q <= page_id;
		end
		if (cmd.match) begin
			match_s1 <= match_c;
		end
		if (do_fill || do_evict) begin
			frame_page_q[hand_q] <= page_q;
		end
		if (fire) begin
			hit_q     <= do_hit_set;
			evicted_q <= do_evict;
			victim_q  <= do_evict ? frame_page_q[hand_q] : '0;
			frame_q   <= do_hit_set ? hit_idx : hand_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign evicted     = evicted_q;
	assign victim_page = victim_q;
	assign frame_index = frame_q;

endmodule

/* dv/tb_clock_page_replacement.sv */
module tb_clock_page_replacement;
	timeunit 1ns;
	timeprecision 1ps;

	import cpr_pkg::*;

	localparam int POOL_FRAMES = 16;
	localparam int PAGE_W      = 16;
	localparam int FRAME_W     = 4;
	localparam int SETTLE      = 24;
	localparam int HOLD_LEN    = 200;
	localparam int LIMIT       = 200000;

	typedef struct packed {
		logic              hit;
		logic              evicted;
		logic [PAGE_W-1:0] victim;
		logic [FRAME_W-1:0] frame;
	} page_outcome_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [PAGE_W-1:0]   page_id;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                hit;
	logic                evicted;
	logic [PAGE_W-1:0]   victim_page;
	logic [FRAME_W-1:0]  frame_index;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	// predictor state
	logic [PAGE_W-1:0]   fr_page [POOL_FRAMES];
	bit                  fr_valid [POOL_FRAMES];
	bit                  fr_ref [POOL_FRAMES];
	int                  hand;
	int                  resident;
	logic [CAP_W-1:0]    cap_reg;

	page_outcome_t       outcomes_due[$];
	int                  errors;
	int                  cycles = 0;
	int                  idle_pct;
	int                  stall_pct;
	int                  hold_reqs;
	int                  hold_seen;
	int                  hold_left;
	logic [PAGE_W-1:0]   page_base;

	clock_page_replacement #(
		.FRAMES    (POOL_FRAMES),
		.PAGE_BITS (PAGE_W)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.page_id     (page_id),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.evicted     (evicted),
		.victim_page (victim_page),
		.frame_index (frame_index),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int next_hand(input int f, input int lim);
		return (f + 1 >= lim) ? 0 : f + 1;
	endfunction

	function automatic page_outcome_t predict_reference(input logic [PAGE_W-1:0] pg);
		page_outcome_t o;
		int            lim;
		int            f;
		o = '0;
		lim = (cap_reg == 0) ? 1 : ((cap_reg > POOL_FRAMES) ? POOL_FRAMES : int'(cap_reg));
		if (hand >= lim)
			hand = 0;
		for (int i = 0; i < POOL_FRAMES; i++) begin
			if (fr_valid[i] && fr_page[i] == pg) begin
				o.hit = 1'b1;
				o.frame = FRAME_W'(i);
				fr_ref[i] = 1'b1;
				break;
			end
		end
		if (!o.hit) begin
			if (resident < lim && !fr_valid[hand]) begin
				o.frame = FRAME_W'(hand);
				fr_page[hand] = pg;
				fr_valid[hand] = 1'b1;
				fr_ref[hand] = 1'b1;
				resident++;
				hand = next_hand(hand, lim);
			end else begin
				for (int s = 0; s <= 2 * lim; s++) begin
					f = hand;
					if (!fr_valid[f]) begin
						o.frame = FRAME_W'(f);
						fr_page[f] = pg;
						fr_valid[f] = 1'b1;
						fr_ref[f] = 1'b1;
						resident++;
						hand = next_hand(f, lim);
						break;
					end
					if (fr_ref[f]) begin
						fr_ref[f] = 1'b0;
						hand = next_hand(f, lim);
					end else begin
						o.evicted = 1'b1;
						o.victim = fr_page[f];
						o.frame = FRAME_W'(f);
						fr_page[f] = pg;
						fr_ref[f] = 1'b1;
						hand = next_hand(f, lim);
						break;
					end
				end
			end
		end
		return o;
	endfunction

	function automatic logic [PAGE_W-1:0] pick_page();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return page_base + PAGE_W'($urandom_range(0, 19));
		return PAGE_W'($urandom_range(0, 65535));
	endfunction

	task automatic send_page(input logic [PAGE_W-1:0] pg);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		page_id  <= pg;
		do
			@(posedge clk);
		while (in_stall);
		outcomes_due.insert(outcomes_due.size(), predict_reference(pg));
	endtask

	task automatic wait_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outcomes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_POOL_CAPACITY;
		pwdata  <= DATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		cap_reg = v;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic test_fill_and_hit();
		write_capacity(5'd16);
		send_page(16'h0000);
		send_page(16'hFFFF);
		send_page(16'hFFFF);
		send_page(16'h0000);
		wait_until_drained();
	endtask

	// capacity zero acts as one; the hand restarts and frames above stay resident
	task automatic test_capacity_floor();
		write_capacity(5'd0);
		send_page(16'h1234);
		send_page(16'hFFFF);
		send_page(16'hAAAA);
		wait_until_drained();
	endtask

	// occupied frame at the hand below capacity, then an empty frame in the sweep
	task automatic test_capacity_growth();
		write_capacity(5'd8);
		send_page(16'h5555);
		send_page(16'h5556);
		wait_until_drained();
	endtask

	task automatic test_capacity_saturation();
		write_capacity(5'd31);
		send_page(16'h8000);
		send_page(16'h7FFF);
		wait_until_drained();
		write_capacity(5'd17);
		send_page(16'h8000);
		wait_until_drained();
	endtask

	task automatic test_backpressure();
		idle_pct  = 0;
		stall_pct = 0;
		page_base = PAGE_W'($urandom_range(0, 65535));
		hold_reqs++;
		for (int i = 0; i < 24; i++)
			send_page(pick_page());
		wait_until_drained();
	endtask

	task automatic test_random_traffic();
		logic [CAP_W-1:0] caps [8];
		caps = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd9, 5'd2, 5'd17};
		for (int p = 0; p < 8; p++) begin
			write_capacity(caps[p]);
			page_base = PAGE_W'($urandom_range(0, 65535));
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 87; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 87; end
				default: begin idle_pct = 12; stall_pct = 12; end
			endcase
			for (int i = 0; i < 64; i++)
				send_page(pick_page());
			wait_until_drained();
		end
	endtask

	always @(negedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		page_outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (outcomes_due.size() == 0) begin
				$display("%0t unexpected item: hit %b evicted %b victim %h frame %0d",
					$time, hit, evicted, victim_page, frame_index);
				errors++;
			end else begin
				want = outcomes_due[0];
				outcomes_due.delete(0);
				if (hit !== want.hit) begin
					$display("%0t hit: expected %b actual %b", $time, want.hit, hit);
					errors++;
				end
				if (evicted !== want.evicted) begin
					$display("%0t evicted: expected %b actual %b", $time, want.evicted, evicted);
					errors++;
				end
				if (victim_page !== want.victim) begin
					$display("%0t victim_page: expected %h actual %h",
						$time, want.victim, victim_page);
					errors++;
				end
				if (frame_index !== want.frame) begin
					$display("%0t frame_index: expected %0d actual %0d",
						$time, want.frame, frame_index);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		page_id   = '0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		errors    = 0;
		idle_pct  = 0;
		stall_pct = 0;
		hold_reqs = 0;
		hold_seen = 0;
		hold_left = 0;
		page_base = '0;
		hand      = 0;
		resident  = 0;
		cap_reg   = CAP_RESET;
		for (int i = 0; i < POOL_FRAMES; i++) begin
			fr_page[i]  = '0;
			fr_valid[i] = 1'b0;
			fr_ref[i]   = 1'b0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_fill_and_hit();
		test_capacity_floor();
		test_capacity_growth();
		test_capacity_saturation();
		test_backpressure();
		test_random_traffic();
		wait_until_drained();
		if (errors == 0 && outcomes_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
